// ===== design/esd_pkg.sv =====
// Shared types, constants and control program of the descending exchange sort.
`timescale 1ns / 1ps
package esd_pkg;

    localparam int MAX_RECORDS = 32;
    localparam int IDX_W       = $clog2(MAX_RECORDS);
    localparam int CNT_W       = $clog2(MAX_RECORDS + 1);
    localparam int KEY_W       = 16;
    localparam int TAG_W       = 6;
    localparam int REC_W       = KEY_W + TAG_W;
    localparam int STEP_W      = 4;

    typedef logic [STEP_W-1:0] t_step;

    // Program addresses
    localparam t_step STEP_LOAD  = STEP_W'(0);
    localparam t_step STEP_INIT  = STEP_W'(1);
    localparam t_step STEP_RDI   = STEP_W'(2);
    localparam t_step STEP_LDI   = STEP_W'(3);
    localparam t_step STEP_CMP   = STEP_W'(4);
    localparam t_step STEP_RDJ   = STEP_W'(5);
    localparam t_step STEP_WRI   = STEP_W'(6);
    localparam t_step STEP_OINIT = STEP_W'(7);
    localparam t_step STEP_ORD   = STEP_W'(8);
    localparam t_step STEP_EMIT  = STEP_W'(9);
    localparam t_step STEP_OJMP  = STEP_W'(10);

    // Read address source
    typedef enum logic [1:0] {RS_I, RS_J, RS_K} t_rsel;
    // Counter operation for i and k
    typedef enum logic [1:0] {CO_HOLD, CO_ZERO, CO_INC} t_cop;
    // Counter operation for j
    typedef enum logic [1:0] {JO_HOLD, JO_FROM_I, JO_INC} t_jop;
    // Wait condition of a step
    typedef enum logic [1:0] {HD_NONE, HD_IN, HD_OUT} t_hold;
    // Branch condition
    typedef enum logic [2:0] {
        JC_NEXT, JC_ALWAYS, JC_NOT_LAST, JC_FEW, JC_J_DONE, JC_I_MORE, JC_K_DONE
    } t_jc;

    typedef struct packed {
        logic  accept_in;
        t_hold hold;
        t_rsel rd_sel;
        t_cop  i_op;
        t_jop  j_op;
        t_cop  k_op;
        logic  ld_ki;
        logic  swap;
        logic  wr_i;
        logic  emit;
        t_jc   jc;
        t_step target;
    } t_ctl;

    typedef struct packed {
        logic in_valid;
        logic in_last;
        logic few;
        logic j_done;
        logic i_more;
        logic k_done;
        logic out_free;
    } t_stat;

    // Control store: one control word per program step
    function automatic t_ctl ucode(input t_step s);
        t_ctl c;
        c.accept_in = 1'b0;
        c.hold      = HD_NONE;
        c.rd_sel    = RS_K;
        c.i_op      = CO_HOLD;
        c.j_op      = JO_HOLD;
        c.k_op      = CO_HOLD;
        c.ld_ki     = 1'b0;
        c.swap      = 1'b0;
        c.wr_i      = 1'b0;
        c.emit      = 1'b0;
        c.jc        = JC_NEXT;
        c.target    = STEP_LOAD;
        case (s)
            STEP_LOAD: begin
                c.accept_in = 1'b1;
                c.hold      = HD_IN;
                c.jc        = JC_NOT_LAST;
                c.target    = STEP_LOAD;
            end
            STEP_INIT: begin
                c.i_op   = CO_ZERO;
                c.jc     = JC_FEW;
                c.target = STEP_OINIT;
            end
            STEP_RDI: begin
                c.rd_sel = RS_I;
                c.j_op   = JO_FROM_I;
            end
            STEP_LDI: begin
                c.rd_sel = RS_J;
                c.ld_ki  = 1'b1;
            end
            STEP_CMP: begin
                c.swap   = 1'b1;
                c.j_op   = JO_INC;
                c.jc     = JC_J_DONE;
                c.target = STEP_WRI;
            end
            STEP_RDJ: begin
                c.rd_sel = RS_J;
                c.jc     = JC_ALWAYS;
                c.target = STEP_CMP;
            end
            STEP_WRI: begin
                c.wr_i   = 1'b1;
                c.i_op   = CO_INC;
                c.jc     = JC_I_MORE;
                c.target = STEP_RDI;
            end
            STEP_OINIT: begin
                c.k_op = CO_ZERO;
            end
            STEP_ORD: begin
                c.rd_sel = RS_K;
            end
            STEP_EMIT: begin
                c.hold   = HD_OUT;
                c.emit   = 1'b1;
                c.k_op   = CO_INC;
                c.jc     = JC_K_DONE;
                c.target = STEP_LOAD;
            end
            STEP_OJMP: begin
                c.jc     = JC_ALWAYS;
                c.target = STEP_ORD;
            end
            default: begin
                c.jc     = JC_ALWAYS;
                c.target = STEP_LOAD;
            end
        endcase
        return c;
    endfunction

    // Arrival position of the record stored at a count, wrapped to the tag width
    function automatic logic [TAG_W-1:0] make_tag(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+TAG_W-1:0] w;
        w = (CNT_W + TAG_W)'(cnt) + (CNT_W + TAG_W)'(1);
        return w[TAG_W-1:0];
    endfunction

endpackage

// ===== design/exchange_sort_descending_top.sv =====
// Top level of the descending exchange sort block.
//
// Usage: records enter on the input channel (i_in_valid / o_in_stall), one
// transfer per cycle while the block is loading. Each stored record is tagged
// with its arrival position from 1. Records beyond MAX_RECORDS are dropped and
// the set is flagged on o_dropped. A record with i_last_record set closes the
// set; the block then stalls its input, sorts in descending key order and
// sends one result per stored record on the output channel
// (o_out_valid / i_out_stall), o_final_result marking the last one.
// The length of the sort program is set by the single read port of the
// record store that each compare-exchange step waits on; each result then
// passes through a read, an emit and a loop step.
// A stall on the output holds the result in the output register and freezes
// the program at its emit step; nothing is lost.
// Reset (i_rst_n low, synchronous) empties the set, clears the output valid
// and returns the program to loading. Store contents are not cleared.
`timescale 1ns / 1ps
module exchange_sort_descending_top (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [esd_pkg::KEY_W-1:0] i_sort_key,
    input  logic                      i_last_record,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic [esd_pkg::TAG_W-1:0] o_record_tag,
    output logic [esd_pkg::KEY_W-1:0] o_record_key,
    output logic                      o_final_result,
    output logic                      o_dropped
);
    import esd_pkg::*;

    t_ctl  w_ctl;
    t_stat w_stat;
    logic  w_go;

    // Accept input only in the loading step
    assign o_in_stall = !w_ctl.accept_in;

    esd_sequencer u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl),
        .o_go    (w_go)
    );

    esd_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_ctl          (w_ctl),
        .i_go           (w_go),
        .o_stat         (w_stat),
        .i_in_valid     (i_in_valid),
        .i_sort_key     (i_sort_key),
        .i_last_record  (i_last_record),
        .i_out_stall    (i_out_stall),
        .o_out_valid    (o_out_valid),
        .o_record_tag   (o_record_tag),
        .o_record_key   (o_record_key),
        .o_final_result (o_final_result),
        .o_dropped      (o_dropped)
    );

endmodule

// ===== design/esd_sequencer.sv =====
// Step counter, control store lookup and branch logic of the sort block.
`timescale 1ns / 1ps
module esd_sequencer (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  esd_pkg::t_stat i_stat,
    output esd_pkg::t_ctl  o_ctl,
    output logic          o_go
);
    import esd_pkg::*;

    t_step r_step;
    t_step n_step;
    t_ctl  w_ctl;
    logic  w_go;
    logic  w_taken;

    // Fetch the control word of the current step
    assign w_ctl = ucode(r_step);

    // Decide whether the step executes this cycle
    always_comb begin
        case (w_ctl.hold)
            HD_NONE: w_go = 1'b1;
            HD_IN:   w_go = i_stat.in_valid;
            HD_OUT:  w_go = i_stat.out_free;
            default: w_go = 1'b1;
        endcase
    end

    // Evaluate the branch condition
    always_comb begin
        case (w_ctl.jc)
            JC_NEXT:     w_taken = 1'b0;
            JC_ALWAYS:   w_taken = 1'b1;
            JC_NOT_LAST: w_taken = !i_stat.in_last;
            JC_FEW:      w_taken = i_stat.few;
            JC_J_DONE:   w_taken = i_stat.j_done;
            JC_I_MORE:   w_taken = i_stat.i_more;
            JC_K_DONE:   w_taken = i_stat.k_done;
            default:     w_taken = 1'b1;
        endcase
    end

    // Advance, branch or hold the step counter
    always_comb begin
        if (!w_go) begin
            n_step = r_step;
        end else if (w_taken) begin
            n_step = w_ctl.target;
        end else begin
            n_step = r_step + t_step'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_LOAD;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctl = w_ctl;
    assign o_go  = w_go;

endmodule

// ===== design/esd_datapath.sv =====
// Record store, index counters, compare-exchange register and output register.
`timescale 1ns / 1ps
module esd_datapath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  esd_pkg::t_ctl                i_ctl,
    input  logic                         i_go,
    output esd_pkg::t_stat               o_stat,
    input  logic                         i_in_valid,
    input  logic [esd_pkg::KEY_W-1:0]    i_sort_key,
    input  logic                         i_last_record,
    input  logic                         i_out_stall,
    output logic                         o_out_valid,
    output logic [esd_pkg::TAG_W-1:0]    o_record_tag,
    output logic [esd_pkg::KEY_W-1:0]    o_record_key,
    output logic                         o_final_result,
    output logic                         o_dropped
);
    import esd_pkg::*;

    logic [REC_W-1:0] mem [MAX_RECORDS];
    logic [REC_W-1:0] r_rdata;

    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_ovf, n_ovf;
    logic [CNT_W-1:0] r_i, n_i;
    logic [CNT_W-1:0] r_j, n_j;
    logic [CNT_W-1:0] r_k, n_k;
    logic [KEY_W-1:0] r_ki, n_ki;
    logic [TAG_W-1:0] r_ti, n_ti;

    logic             r_out_vld, n_out_vld;
    logic [TAG_W-1:0] r_tag;
    logic [KEY_W-1:0] r_key;
    logic             r_final;
    logic             r_drop;

    logic             w_accept;
    logic             w_room;
    logic             w_out_free;
    logic             w_do_swap;
    logic             w_emit;
    logic             w_wr_en;
    logic [IDX_W-1:0] w_wr_addr;
    logic [REC_W-1:0] w_wr_data;
    logic [IDX_W-1:0] w_rd_addr;
    logic [CNT_W:0]   w_j1, w_i2, w_k1, w_n;

    // Status for the sequencer
    assign w_n        = {1'b0, r_cnt};
    assign w_j1       = {1'b0, r_j} + (CNT_W + 1)'(1);
    assign w_i2       = {1'b0, r_i} + (CNT_W + 1)'(2);
    assign w_k1       = {1'b0, r_k} + (CNT_W + 1)'(1);
    assign w_out_free = !r_out_vld || !i_out_stall;

    assign o_stat.in_valid = i_in_valid;
    assign o_stat.in_last  = i_last_record;
    assign o_stat.few      = w_n < (CNT_W + 1)'(2);
    assign o_stat.j_done   = w_j1 >= w_n;
    assign o_stat.i_more   = w_i2 < w_n;
    assign o_stat.k_done   = w_k1 == w_n;
    assign o_stat.out_free = w_out_free;

    assign w_accept  = i_ctl.accept_in && i_in_valid;
    assign w_room    = r_cnt < CNT_W'(MAX_RECORDS);
    assign w_do_swap = i_go && i_ctl.swap && (r_ki < r_rdata[KEY_W-1:0]);
    assign w_emit    = i_go && i_ctl.emit;

    // Select the write port: load, exchange at j, or write back at i
    always_comb begin
        w_wr_en   = 1'b0;
        w_wr_addr = r_cnt[IDX_W-1:0];
        w_wr_data = {make_tag(r_cnt), i_sort_key};
        if (w_accept && w_room) begin
            w_wr_en = 1'b1;
        end else if (w_do_swap) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_j[IDX_W-1:0];
            w_wr_data = {r_ti, r_ki};
        end else if (i_go && i_ctl.wr_i) begin
            w_wr_en   = 1'b1;
            w_wr_addr = r_i[IDX_W-1:0];
            w_wr_data = {r_ti, r_ki};
        end
    end

    // Select the read address
    always_comb begin
        case (i_ctl.rd_sel)
            RS_I:    w_rd_addr = r_i[IDX_W-1:0];
            RS_J:    w_rd_addr = r_j[IDX_W-1:0];
            RS_K:    w_rd_addr = r_k[IDX_W-1:0];
            default: w_rd_addr = r_k[IDX_W-1:0];
        endcase
    end

    // Record store with registered read
    always_ff @(posedge i_clk) begin
        if (w_wr_en) begin
            mem[w_wr_addr] <= w_wr_data;
        end
        r_rdata <= mem[w_rd_addr];
    end

    // Next values of counters, set status and the held record
    always_comb begin
        n_cnt = r_cnt;
        n_ovf = r_ovf;
        n_i   = r_i;
        n_j   = r_j;
        n_k   = r_k;
        n_ki  = r_ki;
        n_ti  = r_ti;

        if (w_accept) begin
            if (w_room) begin
                n_cnt = r_cnt + CNT_W'(1);
            end else begin
                n_ovf = 1'b1;
            end
        end

        if (i_go) begin
            case (i_ctl.i_op)
                CO_ZERO: n_i = '0;
                CO_INC:  n_i = r_i + CNT_W'(1);
                default: n_i = r_i;
            endcase
            case (i_ctl.j_op)
                JO_FROM_I: n_j = r_i + CNT_W'(1);
                JO_INC:    n_j = r_j + CNT_W'(1);
                default:   n_j = r_j;
            endcase
            case (i_ctl.k_op)
                CO_ZERO: n_k = '0;
                CO_INC:  n_k = r_k + CNT_W'(1);
                default: n_k = r_k;
            endcase
        end

        // Take the record at i, or exchange with the larger one at j
        if ((i_go && i_ctl.ld_ki) || w_do_swap) begin
            n_ki = r_rdata[KEY_W-1:0];
            n_ti = r_rdata[REC_W-1:KEY_W];
        end

        // Close the set on its final result
        if (w_emit && o_stat.k_done) begin
            n_cnt = '0;
            n_ovf = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_ovf <= 1'b0;
        end else begin
            r_cnt <= n_cnt;
            r_ovf <= n_ovf;
        end
        r_i  <= n_i;
        r_j  <= n_j;
        r_k  <= n_k;
        r_ki <= n_ki;
        r_ti <= n_ti;
    end

    // Output register: load on emit, drop valid once the transfer completes
    always_comb begin
        n_out_vld = r_out_vld;
        if (w_emit) begin
            n_out_vld = 1'b1;
        end else if (r_out_vld && !i_out_stall) begin
            n_out_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= n_out_vld;
        end
        if (w_emit) begin
            r_tag   <= r_rdata[REC_W-1:KEY_W];
            r_key   <= r_rdata[KEY_W-1:0];
            r_final <= o_stat.k_done;
            r_drop  <= r_ovf;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_record_tag   = r_tag;
    assign o_record_key   = r_key;
    assign o_final_result = r_final;
    assign o_dropped      = r_drop;

endmodule
